// File: rtl/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg: project config token parser shared definitions
// Widths, token and grammar codes, result codes and the queued token word.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int STACK_DEPTH = 5;
  localparam int SP_W        = $clog2(STACK_DEPTH);

  // Queue depth must be a power of two: the pointers wrap naturally.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CLASS_W = 4;
  localparam int LINE_W  = 24;
  localparam int OFF_W   = 24;
  localparam int LEN_W   = 16;
  localparam int SPAN_W  = 24;
  localparam int END_W   = SPAN_W + 1;
  localparam int PIDX_W  = 8;

  localparam logic [SPAN_W-1:0] SPAN_MAX  = '1;
  localparam logic [PIDX_W-1:0] PCNT_MAX  = '1;

  typedef enum logic [CLASS_W-1:0] {
    TK_PROJECT = 4'd0,
    TK_NAME    = 4'd1,
    TK_OUTPUT  = 4'd2,
    TK_SOURCES = 4'd3,
    TK_INCLUDE = 4'd4,
    TK_OBRACE  = 4'd5,
    TK_CBRACE  = 4'd6,
    TK_COLON   = 4'd7,
    TK_COMMA   = 4'd8,
    TK_QUOTE   = 4'd9,
    TK_HASH    = 4'd10,
    TK_OTHER   = 4'd11
  } tok_class_t;

  typedef enum logic [3:0] {
    ST_GLOBAL   = 4'd0,
    ST_COMMENT  = 4'd1,
    ST_STRSTART = 4'd2,
    ST_STRAGG   = 4'd3,
    ST_LIST     = 4'd4,
    ST_PROJECT  = 4'd5,
    ST_P_NAME   = 4'd6,
    ST_P_OUT    = 4'd7,
    ST_P_SRC    = 4'd8,
    ST_P_INC    = 4'd9
  } gram_state_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PROJECT = 3'd1,
    EV_ELEMENT = 3'd2,
    EV_SPAN    = 3'd3,
    EV_ERROR   = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    ERR_PROPERTY   = 3'd0,
    ERR_COLON_STR  = 3'd1,
    ERR_COLON_LIST = 3'd2,
    ERR_LIST_DELIM = 3'd3,
    ERR_QUOTE      = 3'd4,
    ERR_GLOBAL     = 3'd5
  } error_t;

  typedef enum logic [1:0] {
    FLD_NAME    = 2'd0,
    FLD_OUTPUT  = 2'd1,
    FLD_SOURCES = 2'd2,
    FLD_INCLUDE = 2'd3
  } field_t;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_PUSH    = 2'd1,
    OP_POP     = 2'd2,
    OP_REPLACE = 2'd3
  } stack_op_t;

  typedef struct packed {
    tok_class_t         cls;
    logic [LINE_W-1:0]  line;
    logic [OFF_W-1:0]   offset;
    logic [LEN_W-1:0]   length;
    logic [END_W-1:0]   tok_end;
  } tok_word_t;

endpackage

// File: rtl/pcp_front.sv
// ----------------------------------------------------------------------------
// pcp_front: token intake and classification
// Folds unknown classes, precomputes the token end offset, feeds the queue.
// ----------------------------------------------------------------------------
module pcp_front import pcp_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CLASS_W-1:0] token_class,
  input  logic [LINE_W-1:0]  token_line,
  input  logic [OFF_W-1:0]   token_offset,
  input  logic [LEN_W-1:0]   token_length,
  input  logic               q_ready,
  output logic               q_push,
  output tok_word_t          q_word
);

  tok_class_t cls;

  always_comb begin
    // fold every unlisted class code onto "other"
    if (token_class > TK_OTHER) begin
      cls = TK_OTHER;
    end else begin
      cls = tok_class_t'(token_class);
    end
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  assign q_word.cls     = cls;
  assign q_word.line    = token_line;
  assign q_word.offset  = token_offset;
  assign q_word.length  = token_length;
  assign q_word.tok_end = END_W'(token_offset) + END_W'(token_length);

endmodule

// File: rtl/pcp_queue.sv
// ----------------------------------------------------------------------------
// pcp_queue: token word queue
// Short FIFO between the intake and the parser core.
// ----------------------------------------------------------------------------
module pcp_queue import pcp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tok_word_t push_word,
  output logic      ready,
  input  logic      pop,
  output logic      valid,
  output tok_word_t head
);

  tok_word_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign ready   = (count != QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push & ready;
  assign do_pop  = pop & valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with split pointers");
`endif

endmodule

// File: rtl/pcp_back.sv
// ----------------------------------------------------------------------------
// pcp_back: grammar stack and event generation
// Runs one token per cycle, unless the output stalls, against the state stack and registers the event.
// ----------------------------------------------------------------------------
module pcp_back import pcp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  tok_word_t          q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         event_kind,
  output logic [1:0]         target_field,
  output logic [SPAN_W-1:0]  span_start,
  output logic [SPAN_W-1:0]  span_length,
  output logic [2:0]         error_kind,
  output logic [PIDX_W-1:0]  project_index
);

  // stack kept as a shift line: entry 0 is the top
  gram_state_t         stack [STACK_DEPTH];
  logic [SP_W-1:0]     sp;
  logic [LINE_W-1:0]   last_line;
  logic                first_seen;
  field_t              cur_field;
  logic [SPAN_W-1:0]   value_start;
  logic [SPAN_W-1:0]   value_len;
  logic                value_empty;
  logic [PIDX_W-1:0]   project_count;
  logic                error_seen;

  gram_state_t         stack_next [STACK_DEPTH];
  logic [SP_W-1:0]     sp_next;
  field_t              cur_field_next;
  logic [SPAN_W-1:0]   value_start_next;
  logic [SPAN_W-1:0]   value_len_next;
  logic                value_empty_next;
  logic [PIDX_W-1:0]   project_count_next;

  gram_state_t         view [STACK_DEPTH];
  logic [SP_W-1:0]     sp_view;
  gram_state_t         st;
  stack_op_t           op;
  gram_state_t         op_state;
  logic                newline;
  logic                pop_comment;
  logic                err;
  error_t              ek;
  event_t              ev;
  field_t              tf;
  logic [SPAN_W-1:0]   s_start;
  logic [SPAN_W-1:0]   s_len;
  logic [END_W-1:0]    diff;
  logic [PIDX_W-1:0]   pc_eff;
  logic                step;

  event_t              ev_q;
  field_t              tf_q;
  error_t              ek_q;
  logic [SPAN_W-1:0]   s_start_q;
  logic [SPAN_W-1:0]   s_len_q;
  logic [PIDX_W-1:0]   pidx_q;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign step  = q_pop;

  always_comb begin
    newline     = !first_seen || (q_word.line > last_line);
    pop_comment = newline && (stack[0] == ST_COMMENT) && (sp != '0);

    // drop a comment that ends at this line break
    for (int i = 0; i < STACK_DEPTH - 1; i++) begin
      view[i] = pop_comment ? stack[i+1] : stack[i];
    end
    view[STACK_DEPTH-1] = pop_comment ? ST_GLOBAL : stack[STACK_DEPTH-1];
    sp_view = pop_comment ? (sp - 1'b1) : sp;
    st      = view[0];

    op                 = OP_NONE;
    op_state           = ST_GLOBAL;
    err                = 1'b0;
    ek                 = ERR_PROPERTY;
    ev                 = EV_NONE;
    tf                 = FLD_NAME;
    s_start            = '0;
    s_len              = '0;
    diff               = '0;
    cur_field_next     = cur_field;
    value_start_next   = value_start;
    value_len_next     = value_len;
    value_empty_next   = value_empty;
    project_count_next = project_count;

    unique case (st)
      ST_GLOBAL: begin
        if (q_word.cls == TK_PROJECT) begin
          op = OP_PUSH; op_state = ST_PROJECT;
        end else if (q_word.cls == TK_HASH) begin
          op = OP_PUSH; op_state = ST_COMMENT;
        end else begin
          err = 1'b1; ek = ERR_GLOBAL;
        end
      end
      ST_PROJECT: begin
        unique case (q_word.cls)
          TK_NAME:    begin op = OP_PUSH; op_state = ST_P_NAME;  end
          TK_OUTPUT:  begin op = OP_PUSH; op_state = ST_P_OUT;   end
          TK_SOURCES: begin op = OP_PUSH; op_state = ST_P_SRC;   end
          TK_INCLUDE: begin op = OP_PUSH; op_state = ST_P_INC;   end
          TK_HASH:    begin op = OP_PUSH; op_state = ST_COMMENT; end
          TK_CBRACE:  op = OP_POP;
          TK_OBRACE: begin
            ev = EV_PROJECT;
            if (project_count != PCNT_MAX) begin
              project_count_next = project_count + 1'b1;
            end
          end
          default: begin
            err = 1'b1; ek = ERR_PROPERTY;
          end
        endcase
      end
      ST_P_NAME, ST_P_OUT: begin
        if (q_word.cls == TK_COLON) begin
          cur_field_next   = (st == ST_P_NAME) ? FLD_NAME : FLD_OUTPUT;
          value_empty_next = 1'b1;
          op = OP_REPLACE; op_state = ST_STRSTART;
        end else begin
          err = 1'b1; ek = ERR_COLON_STR;
        end
      end
      ST_P_SRC, ST_P_INC: begin
        if (q_word.cls == TK_COLON) begin
          cur_field_next = (st == ST_P_SRC) ? FLD_SOURCES : FLD_INCLUDE;
          op = OP_REPLACE; op_state = ST_LIST;
        end else begin
          err = 1'b1; ek = ERR_COLON_LIST;
        end
      end
      ST_LIST: begin
        unique case (q_word.cls)
          TK_CBRACE: op = OP_POP;
          TK_OBRACE, TK_COMMA: begin
            ev               = EV_ELEMENT;
            tf               = cur_field;
            value_empty_next = 1'b1;
            op = OP_PUSH; op_state = ST_STRSTART;
          end
          TK_HASH: begin op = OP_PUSH; op_state = ST_COMMENT; end
          default: begin
            err = 1'b1; ek = ERR_LIST_DELIM;
          end
        endcase
      end
      ST_STRSTART: begin
        if (q_word.cls == TK_QUOTE) begin
          op = OP_REPLACE; op_state = ST_STRAGG;
        end else if (q_word.cls == TK_HASH) begin
          op = OP_PUSH; op_state = ST_COMMENT;
        end else begin
          err = 1'b1; ek = ERR_QUOTE;
        end
      end
      ST_STRAGG: begin
        if (q_word.cls == TK_QUOTE) begin
          op = OP_POP;
        end else begin
          if (value_empty) begin
            // open a fresh span at this token
            value_start_next = q_word.offset;
            value_len_next   = SPAN_W'(q_word.length);
            value_empty_next = (q_word.length == '0);
          end else if (q_word.tok_end < END_W'(value_start)) begin
            value_len_next = '0;
          end else begin
            diff           = q_word.tok_end - END_W'(value_start);
            value_len_next = diff[END_W-1] ? SPAN_MAX : diff[SPAN_W-1:0];
          end
          ev      = EV_SPAN;
          tf      = cur_field;
          s_start = value_start_next;
          s_len   = value_len_next;
        end
      end
      default: ;
    endcase

    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_next[i] = view[i];
    end
    sp_next = sp_view;
    case (op)
      OP_PUSH: begin
        // a push onto a full stack is dropped
        if (sp_view != SP_W'(STACK_DEPTH - 1)) begin
          stack_next[0] = op_state;
          for (int i = 1; i < STACK_DEPTH; i++) begin
            stack_next[i] = view[i-1];
          end
          sp_next = sp_view + 1'b1;
        end
      end
      OP_POP: begin
        if (sp_view != '0) begin
          for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            stack_next[i] = view[i+1];
          end
          stack_next[STACK_DEPTH-1] = ST_GLOBAL;
          sp_next = sp_view - 1'b1;
        end
      end
      OP_REPLACE: stack_next[0] = op_state;
      default: ;
    endcase

    if (err) begin
      ev = EV_ERROR;
    end

    pc_eff = error_seen ? project_count : project_count_next;

    // stuck in error: report nothing
    if (error_seen) begin
      ev      = EV_NONE;
      tf      = FLD_NAME;
      ek      = ERR_PROPERTY;
      s_start = '0;
      s_len   = '0;
      err     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack[i] <= ST_GLOBAL;
      end
      sp            <= '0;
      last_line     <= '0;
      first_seen    <= 1'b0;
      cur_field     <= FLD_NAME;
      value_start   <= '0;
      value_len     <= '0;
      value_empty   <= 1'b1;
      project_count <= '0;
      error_seen    <= 1'b0;
    end else if (step && !error_seen) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack[i] <= stack_next[i];
      end
      sp            <= sp_next;
      cur_field     <= cur_field_next;
      value_start   <= value_start_next;
      value_len     <= value_len_next;
      value_empty   <= value_empty_next;
      project_count <= project_count_next;
      if (err) begin
        error_seen <= 1'b1;
      end else begin
        first_seen <= 1'b1;
        last_line  <= q_word.line;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ev_q      <= ev;
      tf_q      <= tf;
      ek_q      <= ek;
      s_start_q <= s_start;
      s_len_q   <= s_len;
      pidx_q    <= (pc_eff == '0) ? '0 : (pc_eff - 1'b1);
    end
  end

  assign event_kind    = ev_q;
  assign target_field  = tf_q;
  assign error_kind    = ek_q;
  assign span_start    = s_start_q;
  assign span_length   = s_len_q;
  assign project_index = pidx_q;

`ifndef NO_ASSERTIONS
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen |=> error_seen)
    else $error("error flag cleared without reset");

  a_stack_floor: assert property (@(posedge clk) disable iff (rst)
    (sp == '0) |-> (stack[0] == ST_GLOBAL))
    else $error("empty stack top is not global scope");

  a_error_event: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == EV_ERROR)) |-> error_seen)
    else $error("error event without error flag");

  a_count_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (project_count != '0) |=> (project_count != '0))
    else $error("project count wrapped");
`endif

endmodule

// File: rtl/project_config_token_parser_top.sv
// ----------------------------------------------------------------------------
// project_config_token_parser_top: project config token parser
// Pushdown parser over classified tokens, one event word per token.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one classified token word per
//   accept: class, line, byte offset and length. Output channel
//   (out_valid/out_ready) returns exactly one event word per token, in order:
//   nothing, new project, new list element, string span update or syntax
//   error, with the current project index.
//   An accepted word is written into the queue, and the core then registers
//   its event in the output register.
//   Throughput: one token per cycle while the receiver keeps up, set by the
//   grammar stack update in the parser core.
//   A two-word queue separates intake from the core; when the receiver
//   stalls, the core holds its event register and the queue fills, then
//   in_ready drops.
//   After a syntax error every later token yields a "nothing" event until
//   reset. Reset (rst, synchronous) empties the queue and the output
//   register, returns the stack to global scope and clears all counters.
// ----------------------------------------------------------------------------
module project_config_token_parser_top import pcp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CLASS_W-1:0] token_class,
  input  logic [LINE_W-1:0]  token_line,
  input  logic [OFF_W-1:0]   token_offset,
  input  logic [LEN_W-1:0]   token_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         event_kind,
  output logic [1:0]         target_field,
  output logic [SPAN_W-1:0]  span_start,
  output logic [SPAN_W-1:0]  span_length,
  output logic [2:0]         error_kind,
  output logic [PIDX_W-1:0]  project_index
);

  logic      q_ready;
  logic      q_push;
  tok_word_t q_word_in;
  logic      q_valid;
  logic      q_pop;
  tok_word_t q_head;

  pcp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .token_class  (token_class),
    .token_line   (token_line),
    .token_offset (token_offset),
    .token_length (token_length),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_word       (q_word_in)
  );

  pcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_word_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  pcp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_word        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .target_field  (target_field),
    .span_start    (span_start),
    .span_length   (span_length),
    .error_kind    (error_kind),
    .project_index (project_index)
  );

endmodule
